FILE: sv/round_robin_task_scheduler_core_defines.svh
// assertion macros for the round-robin task scheduler core
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef ROUND_ROBIN_TASK_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RRTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RRTS_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define RRTS_ASSERT(name, prop, msg)
`define RRTS_ASSERT_NEVER(name, expr, msg)
`endif

`endif

FILE: sv/rrts_pkg.sv
// shared types and constants of the round-robin task scheduler core
// no dependencies
package rrts_pkg;

  localparam int DEF_MAX_TASKS = 16;
  localparam int DEF_PID_BITS  = 16;

  localparam int KIND_W        = 2;
  localparam int PID_PORT_W    = 16;
  localparam int STATUS_W      = 2;
  localparam int SLOT_PORT_W   = 4;
  localparam int COUNT_PORT_W  = 5;
  localparam int QUANTUM_W     = 16;
  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd10;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_CUR,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan_start;
    logic scan_run;
    logic cur_read;
  } dp_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic scan_done;
  } dp_stat_t;

endpackage

FILE: sv/rrts_ctrl.sv
// sequencing state machine of the round-robin task scheduler core
// depends on rrts_pkg
module rrts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  rrts_pkg::dp_stat_t stat_i,
  output rrts_pkg::dp_cmd_t  cmd_o,
  output logic               busy,
  output logic               done_o
);

  rrts_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrts_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrts_pkg::S_IDLE: begin
        if (start) state_d = rrts_pkg::S_EXEC;
      end
      rrts_pkg::S_EXEC: begin
        state_d = stat_i.is_lookup ? rrts_pkg::S_SCAN : rrts_pkg::S_CUR;
      end
      rrts_pkg::S_SCAN: begin
        if (stat_i.scan_done) state_d = rrts_pkg::S_CUR;
      end
      rrts_pkg::S_CUR: begin
        state_d = rrts_pkg::S_DONE;
      end
      rrts_pkg::S_DONE: begin
        state_d = rrts_pkg::S_IDLE;
      end
      default: begin
        state_d = rrts_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    busy   = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      rrts_pkg::S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      rrts_pkg::S_EXEC: begin
        cmd_o.exec       = 1'b1;
        cmd_o.scan_start = stat_i.is_lookup;
      end
      rrts_pkg::S_SCAN: begin
        cmd_o.scan_run = 1'b1;
      end
      rrts_pkg::S_CUR: begin
        cmd_o.cur_read = 1'b1;
      end
      rrts_pkg::S_DONE: begin
        done_o = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: sv/rrts_datapath.sv
// task table, counters and result registers of the round-robin task scheduler core
// depends on rrts_pkg
module rrts_datapath #(
  parameter int MAX_TASKS = rrts_pkg::DEF_MAX_TASKS,
  parameter int PID_BITS  = rrts_pkg::DEF_PID_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rrts_pkg::dp_cmd_t                 cmd_i,
  output rrts_pkg::dp_stat_t                stat_o,
  input  logic [rrts_pkg::KIND_W-1:0]       kind_i,
  input  logic [rrts_pkg::PID_PORT_W-1:0]   pid_value_i,
  input  logic                              cfg_we_i,
  input  logic [rrts_pkg::QUANTUM_W-1:0]    cfg_data_i,
  output logic [rrts_pkg::STATUS_W-1:0]     status_o,
  output logic [rrts_pkg::SLOT_PORT_W-1:0]  found_slot_o,
  output logic                              switched_o,
  output logic [rrts_pkg::SLOT_PORT_W-1:0]  current_slot_o,
  output logic [rrts_pkg::PID_PORT_W-1:0]   current_pid_o,
  output logic [rrts_pkg::COUNT_PORT_W-1:0] task_count_o
);

  localparam int SlotW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CntW   = $clog2(MAX_TASKS + 1);
  localparam int QW     = rrts_pkg::QUANTUM_W;
  localparam int SlotPw = rrts_pkg::SLOT_PORT_W;
  localparam int PidPw  = rrts_pkg::PID_PORT_W;
  localparam int CntPw  = rrts_pkg::COUNT_PORT_W;

  // table memory; slot 0 is never written and always reads pid 0
  logic [PID_BITS-1:0] mem [MAX_TASKS];
  logic                wr_en;
  logic [SlotW-1:0]    wr_addr;
  logic [SlotW-1:0]    rd_addr;
  logic [PID_BITS-1:0] rd_data_q;

  logic [CntW-1:0]         count_q, count_d;
  logic [SlotW-1:0]        slot_q, slot_d;
  logic [QW-1:0]           tick_q, tick_d;
  logic [QW-1:0]           quantum_q;
  rrts_pkg::kind_e         kind_q;
  logic [PID_BITS-1:0]     pid_q;
  rrts_pkg::status_e       status_q, status_d;
  logic [SlotW-1:0]        found_q, found_d;
  logic                    switched_q, switched_d;
  logic [CntW-1:0]         scan_idx_q, scan_idx_d;
  logic [SlotW-1:0]        cmp_idx_q;
  logic                    cmp_vld_q, cmp_vld_d;
  logic                    issue;
  logic                    hit;
  logic                    last_cmp;
  logic [QW:0]             tick_inc;
  logic [CntW-1:0]         slot_inc;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= pid_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_addr == '0) begin
      rd_data_q <= '0;
    end else begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign rd_addr  = cmd_i.cur_read ? slot_q : scan_idx_q[SlotW-1:0];
  assign issue    = scan_idx_q < count_q;
  assign hit      = cmp_vld_q && (rd_data_q == pid_q);
  assign last_cmp = cmp_vld_q && ((CntW'(cmp_idx_q) + CntW'(1)) == count_q);
  assign tick_inc = {1'b0, tick_q} + (QW+1)'(1);
  assign slot_inc = CntW'(slot_q) + CntW'(1);

  assign stat_o.is_lookup = (kind_q == rrts_pkg::KIND_LOOKUP);
  assign stat_o.scan_done = hit || last_cmp;

  always_comb begin
    count_d    = count_q;
    slot_d     = slot_q;
    tick_d     = tick_q;
    status_d   = status_q;
    found_d    = found_q;
    switched_d = switched_q;
    scan_idx_d = scan_idx_q;
    cmp_vld_d  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = count_q[SlotW-1:0];

    if (cmd_i.exec) begin
      status_d   = rrts_pkg::ST_OK;
      found_d    = '0;
      switched_d = 1'b0;
      unique case (kind_q)
        rrts_pkg::KIND_ADD: begin
          if (count_q >= CntW'(MAX_TASKS)) begin
            status_d = rrts_pkg::ST_FULL;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        rrts_pkg::KIND_TICK: begin
          if (count_q > CntW'(1)) begin
            if (tick_inc > {1'b0, quantum_q}) begin
              tick_d     = '0;
              switched_d = 1'b1;
              slot_d     = (slot_inc >= count_q) ? '0 : slot_inc[SlotW-1:0];
            end else begin
              tick_d = tick_inc[QW-1:0];
            end
          end
        end
        rrts_pkg::KIND_LOOKUP: begin
          status_d = rrts_pkg::ST_NOT_FOUND;
        end
        rrts_pkg::KIND_NOP: begin
          status_d = rrts_pkg::ST_OK;
        end
        default: begin
          status_d = rrts_pkg::ST_OK;
        end
      endcase
    end

    if (cmd_i.scan_start) begin
      scan_idx_d = '0;
    end

    // one read issued per cycle, compared in the next cycle
    if (cmd_i.scan_run) begin
      if (issue) scan_idx_d = scan_idx_q + CntW'(1);
      cmp_vld_d = issue;
      if (hit) begin
        status_d = rrts_pkg::ST_OK;
        found_d  = cmp_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= CntW'(1);
      slot_q    <= '0;
      tick_q    <= '0;
      quantum_q <= rrts_pkg::QUANTUM_RESET;
      cmp_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      slot_q    <= slot_d;
      tick_q    <= tick_d;
      cmp_vld_q <= cmp_vld_d;
      if (cfg_we_i) quantum_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= rrts_pkg::kind_e'(kind_i);
      pid_q  <= PID_BITS'(pid_value_i);
    end
    status_q   <= status_d;
    found_q    <= found_d;
    switched_q <= switched_d;
    scan_idx_q <= scan_idx_d;
    cmp_idx_q  <= scan_idx_q[SlotW-1:0];
  end

  assign status_o       = status_q;
  assign found_slot_o   = SlotPw'(found_q);
  assign switched_o     = switched_q;
  assign current_slot_o = SlotPw'(slot_q);
  assign current_pid_o  = PidPw'(rd_data_q);
  assign task_count_o   = CntPw'(count_q);

endmodule

FILE: sv/round_robin_task_scheduler_core.sv
// Round-robin task scheduler core: a table of task pids with a running slot
// and a tick counter. Raise start for one cycle while busy is low to hand
// over a word (kind_i, pid_value_i); the result word shows up later on the
// result ports for exactly one cycle, marked by done_o, and the receiver
// cannot stall it, so capture it on that cycle. Add, tick and the unused
// kind pass through execute, current pid read and result before the next
// word can be accepted. A lookup walks the table through the single
// registered read port, one slot per cycle, until a hit or the last task.
// The quantum register is written through the cfg port (always ready);
// write it only while the block is idle. After reset the table holds pid 0
// in slot 0, which is the running task, and the quantum is 10.
// depends on rrts_pkg, rrts_ctrl, rrts_datapath and the defines header

`include "round_robin_task_scheduler_core_defines.svh"

module round_robin_task_scheduler_core #(
  parameter int MAX_TASKS = rrts_pkg::DEF_MAX_TASKS,
  parameter int PID_BITS  = rrts_pkg::DEF_PID_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [rrts_pkg::KIND_W-1:0]       kind_i,
  input  logic [rrts_pkg::PID_PORT_W-1:0]   pid_value_i,
  // quantum register write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rrts_pkg::QUANTUM_W-1:0]    cfg_data_i,
  // result word, valid while done_o is high
  output logic                              done_o,
  output logic [rrts_pkg::STATUS_W-1:0]     status_o,
  output logic [rrts_pkg::SLOT_PORT_W-1:0]  found_slot_o,
  output logic                              switched_o,
  output logic [rrts_pkg::SLOT_PORT_W-1:0]  current_slot_o,
  output logic [rrts_pkg::PID_PORT_W-1:0]   current_pid_o,
  output logic [rrts_pkg::COUNT_PORT_W-1:0] task_count_o
);

  rrts_pkg::dp_cmd_t  cmd;
  rrts_pkg::dp_stat_t stat;
  logic               cfg_we;

  // the register sits in the datapath and can take a write every cycle
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // sequencer: idle, execute, optional table scan, current pid read, result
  rrts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // table memory, task count, running slot, tick counter, quantum, result regs
  rrts_datapath #(
    .MAX_TASKS (MAX_TASKS),
    .PID_BITS  (PID_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .kind_i         (kind_i),
    .pid_value_i    (pid_value_i),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data_i),
    .status_o       (status_o),
    .found_slot_o   (found_slot_o),
    .switched_o     (switched_o),
    .current_slot_o (current_slot_o),
    .current_pid_o  (current_pid_o),
    .task_count_o   (task_count_o)
  );

  // an accepted word keeps the block busy on the next cycle
  `RRTS_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")

  // after the result strobe the block is ready for the next word
  `RRTS_ASSERT(a_done_idle, done_o |=> !busy, "block still busy after result")

  // a task switch only comes from a tick, which never reports a slot or error
  `RRTS_ASSERT_NEVER(a_switch_clean,
    done_o && switched_o && (status_o != rrts_pkg::ST_OK || found_slot_o != '0),
    "switch reported with nonzero status or slot")

endmodule
